/* hdl/sva_pkg.sv */
// shared types and constants for the synth voice allocator
// used by sva_voice_store and synth_voice_allocator, no dependencies
`default_nettype none

package sva_pkg;

   localparam int NUM_VOICES = 8;
   localparam int VIDX_W     = $clog2(NUM_VOICES);
   localparam int NOTE_W     = 7;
   localparam int AGE_W      = 16;
   localparam int CHAN_W     = 5;
   localparam int MAP_W      = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // one write to the voice state, fields enabled separately
   typedef struct packed {
      logic              busy_we;
      logic              busy;
      logic              note_we;
      logic [NOTE_W-1:0] note;
      logic              age_we;
      logic [AGE_W-1:0]  age;
      logic [VIDX_W-1:0] idx;
   } voice_wr_type;

   typedef struct packed {
      logic              busy;
      logic [NOTE_W-1:0] note;
      logic [AGE_W-1:0]  age;
   } voice_rd_type;

endpackage

`default_nettype wire

/* hdl/sva_voice_store.sv */
// per-voice state: busy flags, held key and age, one read and one write port
// depends on sva_pkg
`default_nettype none

module sva_voice_store
   import sva_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [VIDX_W-1:0] rd_idx,
   output voice_rd_type           rd_data,
   input  wire voice_wr_type      wr
);

   logic [NUM_VOICES-1:0] busy_ff;
   logic [NOTE_W-1:0]     note_ff [NUM_VOICES];
   logic [AGE_W-1:0]      age_ff  [NUM_VOICES];

   // key and age of a free voice are never looked at, so only busy resets
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (wr.busy_we) begin
         busy_ff[wr.idx] <= wr.busy;
      end
      if (wr.note_we) begin
         note_ff[wr.idx] <= wr.note;
      end
      if (wr.age_we) begin
         age_ff[wr.idx] <= wr.age;
      end
   end

   always_comb begin
      rd_data.busy = busy_ff[rd_idx];
      rd_data.note = note_ff[rd_idx];
      rd_data.age  = age_ff[rd_idx];
   end

endmodule

`default_nettype wire

/* hdl/synth_voice_allocator.sv */
// top level of the voice allocator: handshakes, channel map, scan sequencer
// depends on sva_pkg and sva_voice_store
`default_nettype none

// Polyphonic voice allocator with oldest-note stealing. One transaction is
// taken at a time: req_tready is high only while the sequencer is idle. The
// sequencer walks the eight voices one per clock through a single compare
// and increment unit. A note-on passes from the accepting idle state through
// the scan, which ends early when a free voice is found, then a voice update
// if a voice is granted, then the result state; note-off and tick scan all
// eight voices before the result state, and the unused command goes from
// idle straight to the result state. A new transaction may be accepted while
// the previous result still waits on rsp_tready; it then waits in its result
// state. The channel map is written through csr_we/csr_wdata and must only
// change while idle; after reset every voice sits on channel 1. Every
// transaction gives one result.

module synth_voice_allocator
   import sva_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // channel[4:0], note_key[11:5], note_velocity[18:12], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // granted[0], voice_index[3:1], stolen[4], grant_key[11:5],
   // grant_velocity[18:12], released_mask[26:19], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [MAP_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic                  ch_valid_ff, ch_valid_in;
   logic [3:0]            ch0_ff, ch0_in;
   logic [NOTE_W-1:0]     key_ff, key_in;
   logic [NOTE_W-1:0]     vel_ff, vel_in;
   logic [VIDX_W-1:0]     idx_ff, idx_in;
   logic                  old_found_ff, old_found_in;
   logic [VIDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [AGE_W-1:0]      best_age_ff, best_age_in;
   logic [NUM_VOICES-1:0] mask_ff, mask_in;
   logic [VIDX_W-1:0]     pick_ff, pick_in;
   logic                  granted_ff, granted_in;
   logic                  stolen_ff, stolen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [MAP_W-1:0]      map_ff;

   voice_rd_type          rd;
   voice_wr_type          wr;

   logic                  vmatch;
   logic                  last;
   logic                  age_gt;
   logic [AGE_W-1:0]      age_inc;
   logic                  take_old;
   logic [3:0]            map_chan;
   logic [CHAN_W-1:0]     req_chan;

   sva_voice_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (idx_ff),
      .rd_data (rd),
      .wr      (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else if (csr_we) begin
         map_ff <= csr_wdata;
      end
   end

   assign req_chan = req_tdata[CHAN_W-1:0];
   assign map_chan = map_ff[{idx_ff, 2'b00} +: 4];
   assign vmatch   = ch_valid_ff && (map_chan == ch0_ff);
   assign last     = (idx_ff == VIDX_W'(NUM_VOICES - 1));

   // the one shared compare and increment unit
   assign age_gt   = rd.age > best_age_ff;
   assign age_inc  = rd.age + AGE_W'(1);
   assign take_old = vmatch && rd.busy && (!old_found_ff || age_gt);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ch_valid_in  = ch_valid_ff;
      ch0_in       = ch0_ff;
      key_in       = key_ff;
      vel_in       = vel_ff;
      idx_in       = idx_ff;
      old_found_in = old_found_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      mask_in      = mask_ff;
      pick_in      = pick_ff;
      granted_in   = granted_ff;
      stolen_in    = stolen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;
      wr.idx       = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in       = cmd_type'(req_tuser);
               ch_valid_in  = (req_chan >= CHAN_W'(1)) && (req_chan <= CHAN_W'(16));
               ch0_in       = 4'(req_chan - CHAN_W'(1));
               key_in       = req_tdata[CHAN_W +: NOTE_W];
               vel_in       = req_tdata[CHAN_W+NOTE_W +: NOTE_W];
               idx_in       = '0;
               old_found_in = 1'b0;
               best_idx_in  = '0;
               best_age_in  = '0;
               mask_in      = '0;
               pick_in      = '0;
               granted_in   = 1'b0;
               stolen_in    = 1'b0;
               state_in     = (cmd_type'(req_tuser) == CMD_UNUSED) ? S_DONE : S_SCAN;
            end
         end

         S_SCAN: begin
            if (!last) begin
               idx_in = idx_ff + VIDX_W'(1);
            end
            unique case (cmd_ff)
               CMD_NOTE_ON: begin
                  if (vmatch && !rd.busy) begin
                     // lowest free voice wins outright
                     pick_in    = idx_ff;
                     granted_in = 1'b1;
                     stolen_in  = 1'b0;
                     state_in   = S_WRITE;
                  end else begin
                     if (take_old) begin
                        old_found_in = 1'b1;
                        best_idx_in  = idx_ff;
                        best_age_in  = rd.age;
                     end
                     if (last) begin
                        granted_in = old_found_in;
                        stolen_in  = old_found_in;
                        pick_in    = best_idx_in;
                        state_in   = old_found_in ? S_WRITE : S_DONE;
                     end
                  end
               end
               CMD_NOTE_OFF: begin
                  if (rd.busy && vmatch && (rd.note == key_ff)) begin
                     wr.busy_we      = 1'b1;
                     wr.busy         = 1'b0;
                     mask_in[idx_ff] = 1'b1;
                  end
                  if (last) begin
                     state_in = S_DONE;
                  end
               end
               CMD_TICK: begin
                  if (rd.busy && (rd.age != AGE_MAX)) begin
                     wr.age_we = 1'b1;
                     wr.age    = age_inc;
                  end
                  if (last) begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_WRITE: begin
            wr.idx     = pick_ff;
            wr.busy_we = 1'b1;
            wr.busy    = 1'b1;
            wr.note_we = 1'b1;
            wr.note    = key_ff;
            wr.age_we  = 1'b1;
            wr.age     = '0;
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {
                  (RSP_DATA_W - 27)'(0),
                  (cmd_ff == CMD_NOTE_OFF) ? mask_ff : NUM_VOICES'(0),
                  granted_ff ? vel_ff : NOTE_W'(0),
                  granted_ff ? key_ff : NOTE_W'(0),
                  granted_ff && stolen_ff,
                  granted_ff ? pick_ff : VIDX_W'(0),
                  granted_ff
               };
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      ch_valid_ff  <= ch_valid_in;
      ch0_ff       <= ch0_in;
      key_ff       <= key_in;
      vel_ff       <= vel_in;
      idx_ff       <= idx_in;
      old_found_ff <= old_found_in;
      best_idx_ff  <= best_idx_in;
      best_age_ff  <= best_age_in;
      mask_ff      <= mask_in;
      pick_ff      <= pick_in;
      granted_ff   <= granted_in;
      stolen_ff    <= stolen_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // a new result only comes out of the result state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the result state");

   // no grant means no voice index and no steal
   a_no_grant_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[0]) |-> (rsp_data_ff[4:1] == 4'd0))
      else $error("voice fields set without a grant");

   // a release and a grant never share one result
   a_release_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[26:19] != 8'd0)) |-> !rsp_data_ff[0])
      else $error("released mask together with a grant");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for synth_voice_allocator: directed table, a stealing run,
// then random phases with idling and backpressure, every result checked in order
// depends on sva_pkg and the allocator rtl

module tb
   import sva_pkg::*;
;

   localparam int CYCLE_LIMIT     = 200_000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS     = 230;
   localparam int KEY_POOL        = 6;

   typedef struct packed {
      cmd_type           cmd;
      logic [CHAN_W-1:0] channel;
      logic [NOTE_W-1:0] key;
      logic [NOTE_W-1:0] velocity;
   } midi_event_type;

   // laid out as rsp_tdata, msb first
   typedef struct packed {
      logic [4:0]        fill;
      logic [7:0]        released_mask;
      logic [NOTE_W-1:0] grant_velocity;
      logic [NOTE_W-1:0] grant_key;
      logic              stolen;
      logic [2:0]        voice_index;
      logic              granted;
   } alloc_result_type;

   typedef struct packed {
      midi_event_type   ev;
      logic             typed;
      alloc_result_type want;
   } dir_row_type;

   localparam alloc_result_type NO_RESULT = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [MAP_W-1:0]      csr_wdata = '0;

   // predictor copy of voice state and channel map
   logic              slot_active [NUM_VOICES];
   logic [NOTE_W-1:0] slot_key    [NUM_VOICES];
   logic [AGE_W-1:0]  slot_age    [NUM_VOICES];
   logic [MAP_W-1:0]  map_shadow = '0;
   logic [NOTE_W-1:0] key_pool    [KEY_POOL];

   alloc_result_type due_allocations [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   bit               rsp_hold_request = 1'b0;

   synth_voice_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic alloc_result_type predict_allocation(midi_event_type ev);
      alloc_result_type r;
      int               pick, oldest, v;
      logic             chan_ok;
      logic [3:0]       ch0;
      r = '0;
      pick = -1;
      oldest = -1;
      chan_ok = (ev.channel >= 5'd1) && (ev.channel <= 5'd16);
      ch0 = 4'(ev.channel - 5'd1);
      case (ev.cmd)
         CMD_NOTE_ON: begin
            if (chan_ok) begin
               for (v = 0; v < NUM_VOICES; v++) begin
                  if (pick < 0 && map_shadow[4*v +: 4] == ch0) begin
                     if (!slot_active[v])
                        pick = v;
                     else if (oldest < 0 || slot_age[v] > slot_age[oldest])
                        oldest = v;
                  end
               end
            end
            if (pick < 0)
               pick = oldest;
            if (pick >= 0) begin
               r.granted = 1'b1;
               r.voice_index = pick[2:0];
               r.stolen = slot_active[pick];
               r.grant_key = ev.key;
               r.grant_velocity = ev.velocity;
               slot_active[pick] = 1'b1;
               slot_key[pick] = ev.key;
               slot_age[pick] = '0;
            end
         end
         CMD_NOTE_OFF: begin
            for (v = 0; v < NUM_VOICES; v++) begin
               if (chan_ok && slot_active[v] && map_shadow[4*v +: 4] == ch0 &&
                   slot_key[v] == ev.key) begin
                  slot_active[v] = 1'b0;
                  r.released_mask[v] = 1'b1;
               end
            end
         end
         CMD_TICK: begin
            for (v = 0; v < NUM_VOICES; v++)
               if (slot_active[v] && slot_age[v] != AGE_MAX)
                  slot_age[v] = slot_age[v] + 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic midi_event_type mk_event(cmd_type c, logic [4:0] ch, logic [6:0] k,
                                               logic [6:0] vel);
      midi_event_type ev;
      ev.cmd = c;
      ev.channel = ch;
      ev.key = k;
      ev.velocity = vel;
      return ev;
   endfunction

   function automatic dir_row_type dir_row(cmd_type c, logic [4:0] ch, logic [6:0] k,
                                           logic [6:0] vel, logic typed,
                                           alloc_result_type want);
      dir_row_type row;
      row.ev = mk_event(c, ch, k, vel);
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   function automatic alloc_result_type grant(logic [2:0] idx, logic stolen, logic [6:0] k,
                                              logic [6:0] vel);
      alloc_result_type r;
      r = '0;
      r.granted = 1'b1;
      r.voice_index = idx;
      r.stolen = stolen;
      r.grant_key = k;
      r.grant_velocity = vel;
      return r;
   endfunction

   function automatic alloc_result_type freed(logic [7:0] mask);
      alloc_result_type r;
      r = '0;
      r.released_mask = mask;
      return r;
   endfunction

   // mostly well-formed: mapped channels, a small key set, note-offs for held keys
   function automatic midi_event_type random_event();
      midi_event_type ev;
      int             sel, v;
      sel = $urandom_range(99);
      v = $urandom_range(NUM_VOICES - 1);
      ev.velocity = 7'($urandom_range(127));
      if ($urandom_range(99) < 90)
         ev.key = key_pool[$urandom_range(KEY_POOL - 1)];
      else
         ev.key = 7'($urandom_range(127));
      if ($urandom_range(99) < 85)
         ev.channel = map_shadow[4*v +: 4] + 5'd1;
      else
         ev.channel = 5'($urandom_range(31));
      if (sel < 45)
         ev.cmd = CMD_NOTE_ON;
      else if (sel < 80) begin
         ev.cmd = CMD_NOTE_OFF;
         if (slot_active[v] && $urandom_range(99) < 75) begin
            ev.channel = map_shadow[4*v +: 4] + 5'd1;
            ev.key = slot_key[v];
         end
      end else if (sel < 95)
         ev.cmd = CMD_TICK;
      else
         ev.cmd = CMD_UNUSED;
      return ev;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(midi_event_type ev, logic typed, alloc_result_type want);
      alloc_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, ev.velocity, ev.key, ev.channel};
      req_tuser <= ev.cmd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      res = predict_allocation(ev);
      due_allocations.push_back(typed ? want : res);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (due_allocations.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_map(logic [MAP_W-1:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      map_shadow = value;
   endtask

   function automatic void match_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (due_allocations.size() == 0) begin
            $error("transaction out with none pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = due_allocations.pop_front();
            match_field("granted", 8'(want.granted), 8'(got.granted));
            match_field("voice_index", 8'(want.voice_index), 8'(got.voice_index));
            match_field("stolen", 8'(want.stolen), 8'(got.stolen));
            match_field("grant_key", 8'(want.grant_key), 8'(got.grant_key));
            match_field("grant_velocity", 8'(want.grant_velocity),
                        8'(got.grant_velocity));
            match_field("released_mask", want.released_mask, got.released_mask);
            match_field("zero fill", 8'(want.fill), 8'(got.fill));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver side, with a long hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      dir_row_type   rows [$];
      int            ph, k;
      logic [31:0]   phase_map;
      for (k = 0; k < NUM_VOICES; k++) begin
         slot_active[k] = 1'b0;
         slot_key[k] = '0;
         slot_age[k] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // after reset every voice sits on channel 1
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'd0, 7'd0, 1'b1,
                             grant(3'd0, 1'b0, 7'd0, 7'd0)));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'd127, 7'd127, 1'b1,
                             grant(3'd1, 1'b0, 7'd127, 7'd127)));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd2, 7'd60, 7'd64, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd0, 7'd60, 7'd64, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd17, 7'd60, 7'd64, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd31, 7'd127, 7'd127, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_UNUSED, 5'd1, 7'd127, 7'd127, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_TICK, 5'd1, 7'd0, 7'd0, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_OFF, 5'd1, 7'd127, 7'd0, 1'b1, freed(8'h02)));
      // already free, so nothing is released
      rows.push_back(dir_row(CMD_NOTE_OFF, 5'd1, 7'd127, 7'd0, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_OFF, 5'd0, 7'd0, 7'd0, 1'b1, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_OFF, 5'd16, 7'd0, 7'd0, 1'b1, NO_RESULT));
      for (k = 0; k < 6; k++)
         rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'(10 + k), 7'(20 * k + 1), 1'b0,
                                NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'd10, 7'd1, 1'b0, NO_RESULT));
      rows.push_back(dir_row(CMD_TICK, 5'd31, 7'd127, 7'd127, 1'b0, NO_RESULT));
      // all voices busy: voice 0 is the oldest
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'd20, 7'd127, 1'b0, NO_RESULT));
      // two voices hold the same key
      rows.push_back(dir_row(CMD_NOTE_OFF, 5'd1, 7'd10, 7'd0, 1'b0, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'd21, 7'd5, 1'b0, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'd22, 7'd6, 1'b0, NO_RESULT));
      // equal ages: lowest index is stolen
      rows.push_back(dir_row(CMD_NOTE_ON, 5'd1, 7'd23, 7'd7, 1'b0, NO_RESULT));
      rows.push_back(dir_row(CMD_NOTE_OFF, 5'd1, 7'd0, 7'd0, 1'b0, NO_RESULT));
      foreach (rows[i])
         send_item(rows[i].ev, rows[i].typed, rows[i].want);

      // voices 0 and 1 alone on channel 16: when both are busy, the older one is stolen
      write_map(32'h0000_00FF);
      for (k = 0; k < 2; k++)
         if (slot_active[k])
            send_item(mk_event(CMD_NOTE_OFF, 5'd16, slot_key[k], 7'd0), 1'b0, NO_RESULT);
      send_item(mk_event(CMD_NOTE_ON, 5'd16, 7'd1, 7'd90), 1'b0, NO_RESULT);
      send_item(mk_event(CMD_NOTE_ON, 5'd16, 7'd2, 7'd91), 1'b0, NO_RESULT);
      send_item(mk_event(CMD_TICK, 5'd16, 7'd0, 7'd0), 1'b0, NO_RESULT);
      send_item(mk_event(CMD_NOTE_OFF, 5'd16, 7'd1, 7'd0), 1'b0, NO_RESULT);
      send_item(mk_event(CMD_NOTE_ON, 5'd16, 7'd3, 7'd92), 1'b0, NO_RESULT);
      repeat (3) send_item(mk_event(CMD_TICK, 5'd16, 7'd0, 7'd0), 1'b0, NO_RESULT);
      send_item(mk_event(CMD_NOTE_ON, 5'd16, 7'd4, 7'd93), 1'b0, NO_RESULT);
      send_item(mk_event(CMD_NOTE_ON, 5'd16, 7'd5, 7'd94), 1'b0, NO_RESULT);

      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin phase_map = 32'h7654_3210; send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin phase_map = 32'hFFFF_FFFF; send_idle_pct = 88; rsp_stall_pct = 0;  end
            2: begin phase_map = 32'h1111_0000; send_idle_pct = 0;  rsp_stall_pct = 88; end
            3: begin phase_map = $urandom;      send_idle_pct = 22; rsp_stall_pct = 22; end
            default: begin
               phase_map = 32'h0000_0000;
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         write_map(phase_map);
         for (k = 0; k < KEY_POOL; k++)
            key_pool[k] = 7'($urandom_range(127));
         // receiver stops while items keep coming, so the input stalls
         if (ph == 4)
            rsp_hold_request = 1'b1;
         repeat (PHASE_ITEMS) send_item(random_event(), 1'b0, NO_RESULT);
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
